// ===== rtl/core/cpbl_pkg.sv =====
`timescale 1ns / 1ps

package cpbl_pkg;

    localparam int NUM_LANES = 4;
    localparam int CMD_W     = 16;
    localparam int BUF_W     = 16;
    localparam int CAP_W     = 8;
    localparam int CEIL_W    = 17;
    localparam int SUM_W     = 18;
    localparam int Q_FRAC    = 16;
    // k spans 0..1.0 in Q1.16
    localparam int K_W       = Q_FRAC + 1;
    localparam int KPROD_W   = 2 * K_W;
    localparam int MAG_W     = CMD_W;
    localparam int PROD_W    = MAG_W + CEIL_W;
    // a scaled magnitude stays below the input magnitude, hence below 2^15
    localparam int MQ_W      = CMD_W - 1;

    localparam int ALLOW_LAT = 1 + K_W + 3;
    localparam int LANE_LAT  = 1 + MQ_W + 1;
    localparam int PIPE_LAT  = ALLOW_LAT + LANE_LAT;

    localparam int IN_DATA_W  = NUM_LANES * CMD_W + BUF_W;
    localparam int OUT_DATA_W = 88;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = CEIL_W;

    localparam logic [CFG_IDX_W-1:0] REG_BUFFER_CAPACITY      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_BUFFER_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_CEILING       = 2'd2;

    localparam logic [CAP_W-1:0]  CAPACITY_RST  = 8'd60;
    localparam logic [CAP_W-1:0]  THRESHOLD_RST = 8'd18;
    localparam logic [CEIL_W-1:0] CEILING_RST   = 17'd50000;

    typedef struct packed {
        logic [CAP_W-1:0]  buffer_capacity;
        logic [CAP_W-1:0]  low_buffer_threshold;
        logic [CEIL_W-1:0] output_ceiling;
    } cpbl_cfg_t;

endpackage

// ===== rtl/core/cpbl_div.sv =====
`timescale 1ns / 1ps

module cpbl_div #(
    parameter int NUM_W  = 24,
    parameter int DEN_W  = 8,
    parameter int QUO_W  = 17,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic [QUO_W-1:0]  quo,
    output logic [SIDE_W-1:0] side_out
);

    localparam int RW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic [RW-1:0]     rem_reg  [QUO_W];
    logic [QUO_W-1:0]  quo_reg  [QUO_W];
    logic [DEN_W-1:0]  den_reg  [QUO_W];
    logic [SIDE_W-1:0] side_reg [QUO_W];

    // one quotient bit per stage, most significant first
    for (genvar s = 0; s < QUO_W; s++) begin : g_stage
        localparam int BIT = QUO_W - 1 - s;
        logic [RW-1:0]     rem_cur;
        logic [RW-1:0]     trial;
        logic [DEN_W-1:0]  den_cur;
        logic [QUO_W-1:0]  quo_cur;
        logic [SIDE_W-1:0] side_cur;
        logic              take;

        if (s == 0) begin : g_first
            assign rem_cur  = RW'(num);
            assign den_cur  = den;
            assign quo_cur  = '0;
            assign side_cur = side_in;
        end else begin : g_next
            assign rem_cur  = rem_reg[s-1];
            assign den_cur  = den_reg[s-1];
            assign quo_cur  = quo_reg[s-1];
            assign side_cur = side_reg[s-1];
        end

        assign trial = RW'(den_cur) << BIT;
        assign take  = rem_cur >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s]  <= take ? rem_cur - trial : rem_cur;
                quo_reg[s]  <= {quo_cur[QUO_W-2:0], take};
                den_reg[s]  <= den_cur;
                side_reg[s] <= side_cur;
            end
        end
    end

    assign quo      = quo_reg[QUO_W-1];
    assign side_out = side_reg[QUO_W-1];

endmodule

// ===== rtl/core/cpbl_allow.sv =====
`timescale 1ns / 1ps

module cpbl_allow import cpbl_pkg::*; (
    input  logic              aclk,
    input  logic              en,
    input  cpbl_cfg_t         cfg,
    input  logic [BUF_W-1:0]  power_buffer,
    input  logic              referee_online,
    output logic [CEIL_W-1:0] allowed
);

    logic [CAP_W-1:0]   b_next;
    logic [CAP_W-1:0]   b_reg;
    logic [2:0]         flags_reg;   // {online, zero capacity, low buffer}
    logic [2:0]         flags_div;
    logic [K_W-1:0]     k_div;
    logic [K_W-1:0]     k_cur;
    logic [KPROD_W-1:0] sq_prod;
    logic [K_W-1:0]     k_reg;
    logic [K_W-1:0]     k2_reg;
    logic               low1_reg;
    logic               online1_reg;
    logic [KPROD_W-1:0] cube_prod;
    logic [K_W-1:0]     kk_reg;
    logic               online2_reg;
    logic [KPROD_W-1:0] scaled_prod;
    logic [CEIL_W-1:0]  allowed_reg;

    // clamp the reading to the capacity
    assign b_next = (power_buffer < BUF_W'(cfg.buffer_capacity))
                    ? power_buffer[CAP_W-1:0] : cfg.buffer_capacity;

    always_ff @(posedge aclk) begin
        if (en) begin
            b_reg     <= b_next;
            flags_reg <= {referee_online, cfg.buffer_capacity == '0,
                          b_next < cfg.low_buffer_threshold};
        end
    end

    cpbl_div #(
        .NUM_W  (CAP_W + Q_FRAC),
        .DEN_W  (CAP_W),
        .QUO_W  (K_W),
        .SIDE_W (3)
    ) u_kdiv (
        .aclk     (aclk),
        .en       (en),
        .num      ({b_reg, {Q_FRAC{1'b0}}}),
        .den      (cfg.buffer_capacity),
        .side_in  (flags_reg),
        .quo      (k_div),
        .side_out (flags_div)
    );

    assign k_cur   = flags_div[1] ? '0 : k_div;
    assign sq_prod = KPROD_W'(k_cur) * KPROD_W'(k_cur);

    always_ff @(posedge aclk) begin
        if (en) begin
            k_reg       <= k_cur;
            k2_reg      <= sq_prod[Q_FRAC +: K_W];
            low1_reg    <= flags_div[0];
            online1_reg <= flags_div[2];
        end
    end

    assign cube_prod = KPROD_W'(k2_reg) * KPROD_W'(k_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            kk_reg      <= low1_reg ? cube_prod[Q_FRAC +: K_W] : k2_reg;
            online2_reg <= online1_reg;
        end
    end

    assign scaled_prod = KPROD_W'(kk_reg) * KPROD_W'(cfg.output_ceiling);

    always_ff @(posedge aclk) begin
        if (en) begin
            allowed_reg <= online2_reg ? scaled_prod[Q_FRAC +: CEIL_W]
                                       : cfg.output_ceiling;
        end
    end

    assign allowed = allowed_reg;

endmodule

// ===== rtl/core/cpbl_lane.sv =====
`timescale 1ns / 1ps

module cpbl_lane import cpbl_pkg::*; (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [CMD_W-1:0] cmd,
    input  logic [CEIL_W-1:0]       allowed,
    input  logic [SUM_W-1:0]        sum,
    input  logic                    limit,
    output logic signed [CMD_W-1:0] result
);

    logic [MAG_W-1:0]        mag;
    logic [PROD_W-1:0]       prod_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [CMD_W:0]          side_reg;   // {limit, cmd}
    logic [CMD_W:0]          side_div;
    logic [MQ_W-1:0]         quo;
    logic [CMD_W-1:0]        scaled;
    logic signed [CMD_W-1:0] result_reg;

    assign mag = cmd[CMD_W-1] ? MAG_W'(~cmd + 1'b1) : MAG_W'(cmd);

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= PROD_W'(mag) * PROD_W'(allowed);
            sum_reg  <= sum;
            side_reg <= {limit, cmd};
        end
    end

    // quotient is only meaningful while limiting, where sum > allowed
    cpbl_div #(
        .NUM_W  (PROD_W),
        .DEN_W  (SUM_W),
        .QUO_W  (MQ_W),
        .SIDE_W (CMD_W + 1)
    ) u_mdiv (
        .aclk     (aclk),
        .en       (en),
        .num      (prod_reg),
        .den      (sum_reg),
        .side_in  (side_reg),
        .quo      (quo),
        .side_out (side_div)
    );

    // restore the sign, truncating toward zero
    assign scaled = side_div[CMD_W-1] ? (~CMD_W'(quo) + 1'b1) : CMD_W'(quo);

    always_ff @(posedge aclk) begin
        if (en) begin
            result_reg <= side_div[CMD_W] ? scaled : side_div[CMD_W-1:0];
        end
    end

    assign result = result_reg;

endmodule

// ===== rtl/core/chassis_power_buffer_limiter_top.sv =====
`timescale 1ns / 1ps

// Chassis power-buffer limiter.
// s_ channel: one beat per control tick. s_tdata holds the four wheel commands
// and the buffer reading; s_tuser[0] is the referee-online flag.
// m_ channel: one beat per input beat, in order. m_tdata holds the four
// limited commands and the allowed total; m_tuser[0] is set when scaling hit.
// cfg_ channel: register writes (0 capacity, 1 low threshold, 2 ceiling),
// always ready; write only while no beat is in flight.
// A result reaches m_tvalid through these stages once its input beat is taken:
// 21 stages form the allowed total (a one-bit-per-stage divider for the
// fill ratio, then three multiply stages), 17 stages scale the four wheels in
// parallel lanes (multiply, one-bit-per-stage divider, sign restore), and one
// output register. Throughput is one beat per cycle unless the output stalls.
// When the receiver stalls the output register holds its beat; the pipeline
// keeps taking input until a valid beat reaches its last stage, then s_tready
// drops until the output moves. Reset clears all valid flags and loads the
// register defaults (60, 18, 50000).
module chassis_power_buffer_limiter_top import cpbl_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // drive_left_front, drive_right_front, drive_left_back, drive_right_back,
    // power_buffer
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // referee_online
    input  logic [0:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // limited_left_front, limited_right_front, limited_left_back,
    // limited_right_back, allowed_total, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    // was_limited
    output logic [0:0]            m_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cpbl_cfg_t               cfg_reg;
    logic                    en;
    logic                    accept;
    logic [PIPE_LAT-1:0]     valid_reg;

    logic [CMD_W-1:0]        cmd_in  [NUM_LANES];
    logic [MAG_W-1:0]        mag_in  [NUM_LANES];
    logic [SUM_W-1:0]        sum_in;
    logic [CMD_W-1:0]        cmd_dly_reg [ALLOW_LAT][NUM_LANES];
    logic [SUM_W-1:0]        sum_dly_reg [ALLOW_LAT];

    logic [CEIL_W-1:0]       allowed;
    logic                    limit;
    logic [CEIL_W:0]         tag_dly_reg [LANE_LAT];   // {limit, allowed}
    logic signed [CMD_W-1:0] lane_res [NUM_LANES];

    logic                    m_tvalid_reg;
    logic [OUT_DATA_W-1:0]   m_tdata_reg;
    logic                    m_tuser_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.buffer_capacity      <= CAPACITY_RST;
            cfg_reg.low_buffer_threshold <= THRESHOLD_RST;
            cfg_reg.output_ceiling       <= CEILING_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_BUFFER_CAPACITY: begin
                    cfg_reg.buffer_capacity <= cfg_data[CAP_W-1:0];
                end
                REG_LOW_BUFFER_THRESHOLD: begin
                    cfg_reg.low_buffer_threshold <= cfg_data[CAP_W-1:0];
                end
                REG_OUTPUT_CEILING: begin
                    cfg_reg.output_ceiling <= cfg_data[CEIL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // advance unless a finished beat is blocked behind a stalled output
    assign en       = !(m_tvalid_reg && !m_tready && valid_reg[PIPE_LAT-1]);
    assign s_tready = en;
    assign accept   = s_tvalid && en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[PIPE_LAT-2:0], accept};
        end
    end

    always_comb begin
        sum_in = '0;
        for (int i = 0; i < NUM_LANES; i++) begin
            cmd_in[i] = s_tdata[i*CMD_W +: CMD_W];
            mag_in[i] = cmd_in[i][CMD_W-1] ? MAG_W'(~cmd_in[i] + 1'b1)
                                           : MAG_W'(cmd_in[i]);
            sum_in    = sum_in + SUM_W'(mag_in[i]);
        end
    end

    // hold commands and their sum while the allowed total is formed
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                cmd_dly_reg[0][i] <= cmd_in[i];
            end
            sum_dly_reg[0] <= sum_in;
            for (int d = 1; d < ALLOW_LAT; d++) begin
                cmd_dly_reg[d] <= cmd_dly_reg[d-1];
                sum_dly_reg[d] <= sum_dly_reg[d-1];
            end
        end
    end

    cpbl_allow u_allow (
        .aclk           (aclk),
        .en             (en),
        .cfg            (cfg_reg),
        .power_buffer   (s_tdata[NUM_LANES*CMD_W +: BUF_W]),
        .referee_online (s_tuser[0]),
        .allowed        (allowed)
    );

    assign limit = sum_dly_reg[ALLOW_LAT-1] > SUM_W'(allowed);

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        cpbl_lane u_lane (
            .aclk    (aclk),
            .en      (en),
            .cmd     (cmd_dly_reg[ALLOW_LAT-1][l]),
            .allowed (allowed),
            .sum     (sum_dly_reg[ALLOW_LAT-1]),
            .limit   (limit),
            .result  (lane_res[l])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tag_dly_reg[0] <= {limit, allowed};
            for (int d = 1; d < LANE_LAT; d++) begin
                tag_dly_reg[d] <= tag_dly_reg[d-1];
            end
        end
    end

    // merge the lanes into one output beat
    always_ff @(posedge aclk) begin
        if (en && valid_reg[PIPE_LAT-1]) begin
            m_tdata_reg <= OUT_DATA_W'({tag_dly_reg[LANE_LAT-1][CEIL_W-1:0],
                                        lane_res[3], lane_res[2],
                                        lane_res[1], lane_res[0]});
            m_tuser_reg <= tag_dly_reg[LANE_LAT-1][CEIL_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en && valid_reg[PIPE_LAT-1]) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

// ===== dv/tb_chassis_power_buffer_limiter_top.sv =====
`timescale 1ns / 1ps

module tb_chassis_power_buffer_limiter_top;
    import cpbl_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEMS_PER_PHASE = 225;

    typedef struct packed {
        logic signed [CMD_W-1:0] left_front;
        logic signed [CMD_W-1:0] right_front;
        logic signed [CMD_W-1:0] left_back;
        logic signed [CMD_W-1:0] right_back;
        logic [BUF_W-1:0]        power_buffer;
        logic                    referee_online;
    } wheel_cmd_t;

    typedef struct packed {
        logic signed [CMD_W-1:0] left_front;
        logic signed [CMD_W-1:0] right_front;
        logic signed [CMD_W-1:0] left_back;
        logic signed [CMD_W-1:0] right_back;
        logic [CEIL_W-1:0]       allowed_total;
        logic                    was_limited;
    } limited_cmd_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [0:0]            m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic [CAP_W-1:0]  capacity_q;
    logic [CAP_W-1:0]  threshold_q;
    logic [CEIL_W-1:0] ceiling_q;

    limited_cmd_t pending_limits[$];
    int           mismatch_count = 0;
    int           cycle_count = 0;
    logic         traffic_idle_en = 1'b1;

    chassis_power_buffer_limiter_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[chassis_power_buffer_limiter_top] ERROR");
            $finish;
        end
    end

    function automatic limited_cmd_t predict_limited(wheel_cmd_t w);
        longint       cmd[4];
        longint       mag[4];
        longint       sum;
        longint       allowed;
        longint       b;
        longint       k;
        longint       k2;
        longint       kk;
        longint       m;
        longint       r[4];
        logic         hit;
        limited_cmd_t res;
        cmd[0] = w.left_front;
        cmd[1] = w.right_front;
        cmd[2] = w.left_back;
        cmd[3] = w.right_back;
        sum = 0;
        for (int i = 0; i < 4; i++) begin
            mag[i] = (cmd[i] < 0) ? -cmd[i] : cmd[i];
            sum += mag[i];
        end
        if (!w.referee_online) begin
            allowed = longint'(ceiling_q);
        end else begin
            b = longint'(w.power_buffer);
            if (b > longint'(capacity_q))
                b = longint'(capacity_q);
            // zero capacity reads as an empty buffer
            k = (capacity_q == '0) ? 0 : (b * 65536) / longint'(capacity_q);
            k2 = (k * k) >> 16;
            kk = (b < longint'(threshold_q)) ? ((k2 * k) >> 16) : k2;
            allowed = (kk * longint'(ceiling_q)) >> 16;
        end
        hit = (sum > allowed);
        for (int i = 0; i < 4; i++) begin
            r[i] = cmd[i];
            if (hit) begin
                m = (mag[i] * allowed) / sum;
                r[i] = (cmd[i] < 0) ? -m : m;
            end
        end
        res.left_front    = r[0][CMD_W-1:0];
        res.right_front   = r[1][CMD_W-1:0];
        res.left_back     = r[2][CMD_W-1:0];
        res.right_back    = r[3][CMD_W-1:0];
        res.allowed_total = allowed[CEIL_W-1:0];
        res.was_limited   = hit;
        return res;
    endfunction

    function automatic wheel_cmd_t make_cmd(int lf, int rf, int lb, int rb, int pb, bit online);
        wheel_cmd_t w;
        w.left_front     = lf[CMD_W-1:0];
        w.right_front    = rf[CMD_W-1:0];
        w.left_back      = lb[CMD_W-1:0];
        w.right_back     = rb[CMD_W-1:0];
        w.power_buffer   = pb[BUF_W-1:0];
        w.referee_online = online;
        return w;
    endfunction

    function automatic int random_wheel();
        int v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = 0;
                    3: v = -1;
                    default: v = 1;
                endcase
            end
            1, 2, 3, 4: v = int'($signed(16'($urandom)));
            5, 6, 7: v = $urandom_range(0, 2000);
            default: v = $urandom_range(0, 12000);
        endcase
        if (v > 0 && $urandom_range(0, 1) == 1)
            v = -v;
        return v;
    endfunction

    function automatic wheel_cmd_t random_cmd();
        int pb;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: pb = $urandom_range(0, int'(capacity_q) + 5);
            4, 5: pb = $urandom_range(int'(threshold_q) > 2 ? int'(threshold_q) - 2 : 0,
                                      int'(threshold_q) + 2);
            6, 7: pb = $urandom_range(0, 300);
            default: pb = int'(16'($urandom));
        endcase
        return make_cmd(random_wheel(), random_wheel(), random_wheel(), random_wheel(), pb,
                        $urandom_range(0, 99) < 80);
    endfunction

    task automatic send_cmd(wheel_cmd_t w);
        while (traffic_idle_en && $urandom_range(0, 99) < 9) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {w.power_buffer, w.right_back, w.left_back, w.right_front, w.left_front};
        s_tuser  <= w.referee_online;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        pending_limits.push_back(predict_limited(w));
    endtask

    // Hold the sender until every predicted beat has come back.
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_limits.size() != 0)
            @(posedge aclk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            REG_BUFFER_CAPACITY:      capacity_q  = val[CAP_W-1:0];
            REG_LOW_BUFFER_THRESHOLD: threshold_q = val[CAP_W-1:0];
            REG_OUTPUT_CEILING:       ceiling_q   = val[CEIL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_limits(int cap, int thr, int ceil_val);
        hold_until_drained();
        repeat (PIPE_LAT + 2) @(posedge aclk);
        cfg_write(REG_BUFFER_CAPACITY, CFG_DATA_W'(cap));
        cfg_write(REG_LOW_BUFFER_THRESHOLD, CFG_DATA_W'(thr));
        cfg_write(REG_OUTPUT_CEILING, CFG_DATA_W'(ceil_val));
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_beat();
        limited_cmd_t got;
        limited_cmd_t exp_res;
        got.left_front    = m_tdata[15:0];
        got.right_front   = m_tdata[31:16];
        got.left_back     = m_tdata[47:32];
        got.right_back    = m_tdata[63:48];
        got.allowed_total = m_tdata[80:64];
        got.was_limited   = m_tuser[0];
        if (pending_limits.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected result beat: lf=%0d rf=%0d lb=%0d rb=%0d allowed=%0d lim=%0b",
                         got.left_front, got.right_front, got.left_back, got.right_back,
                         got.allowed_total, got.was_limited);
        end else begin
            exp_res = pending_limits.pop_front();
            if (got.left_front !== exp_res.left_front ||
                got.right_front !== exp_res.right_front ||
                got.left_back !== exp_res.left_back ||
                got.right_back !== exp_res.right_back ||
                got.allowed_total !== exp_res.allowed_total ||
                got.was_limited !== exp_res.was_limited) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("mismatch exp: lf=%0d rf=%0d lb=%0d rb=%0d allowed=%0d lim=%0b",
                             exp_res.left_front, exp_res.right_front, exp_res.left_back,
                             exp_res.right_back, exp_res.allowed_total, exp_res.was_limited);
                    $display("         got: lf=%0d rf=%0d lb=%0d rb=%0d allowed=%0d lim=%0b",
                             got.left_front, got.right_front, got.left_back, got.right_back,
                             got.allowed_total, got.was_limited);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            check_beat();
        m_tready <= !(traffic_idle_en && $urandom_range(0, 99) < 9);
    end

    task automatic test_reset_defaults();
        // zero sum with an empty buffer: allowed is 0, nothing to scale
        send_cmd(make_cmd(0, 0, 0, 0, 0, 1));
        send_cmd(make_cmd(32767, 32767, 32767, 32767, 60, 1));
        send_cmd(make_cmd(-32768, -32768, -32768, -32768, 65535, 1));
        // cube law just below the threshold, square law at it
        send_cmd(make_cmd(32767, -32768, 1, -1, 17, 1));
        send_cmd(make_cmd(32767, -32768, 1, -1, 18, 1));
        send_cmd(make_cmd(1000, -2000, 3000, -4000, 30, 1));
        send_cmd(make_cmd(-32768, 32767, -32768, 32767, 0, 0));
        // sum exactly at the bound, then one above it
        send_cmd(make_cmd(12500, -12500, 12500, -12500, 0, 0));
        send_cmd(make_cmd(12501, -12500, 12500, -12500, 0, 0));
        send_cmd(make_cmd(5, -7, 0, 3, 59, 1));
    endtask

    task automatic test_zero_capacity();
        apply_limits(0, 255, 131071);
        send_cmd(make_cmd(100, -100, 100, -100, 40, 1));
        send_cmd(make_cmd(0, 0, 0, 0, 65535, 1));
        send_cmd(make_cmd(32767, -32768, 32767, -32768, 200, 0));
    endtask

    task automatic test_register_extremes();
        apply_limits(1, 0, 0);
        send_cmd(make_cmd(1, -1, 0, 0, 1, 1));
        send_cmd(make_cmd(0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(-32768, 32767, 2, -3, 65535, 0));
        apply_limits(255, 255, 131071);
        send_cmd(make_cmd(32767, 32767, 32767, 32767, 255, 1));
        send_cmd(make_cmd(-32768, -32768, -32768, -32768, 0, 0));
        send_cmd(make_cmd(32767, -32768, 32767, -32768, 254, 1));
        send_cmd(make_cmd(-20000, 15000, -10000, 5000, 128, 1));
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: apply_limits(int'(CAPACITY_RST), int'(THRESHOLD_RST), int'(CEILING_RST));
                3: apply_limits(255, $urandom_range(0, 255), 131071);
                4: apply_limits(1, 0, int'(17'($urandom)));
                default: apply_limits($urandom_range(1, 255), $urandom_range(0, 255),
                                      int'(17'($urandom)));
            endcase
            // one phase runs with both sides always ready
            traffic_idle_en = (phase != 2);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n == ITEMS_PER_PHASE / 2)
                    hold_until_drained();
                send_cmd(random_cmd());
            end
        end
        traffic_idle_en = 1'b1;
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        m_tready    = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        capacity_q  = CAPACITY_RST;
        threshold_q = THRESHOLD_RST;
        ceiling_q   = CEILING_RST;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_zero_capacity();
        test_register_extremes();
        test_random_traffic();

        hold_until_drained();
        repeat (PIPE_LAT + 4) @(posedge aclk);
        if (mismatch_count == 0 && pending_limits.size() == 0)
            $display("[chassis_power_buffer_limiter_top] OK");
        else
            $display("[chassis_power_buffer_limiter_top] ERROR");
        $finish;
    end

endmodule
